>>> sv/ght_pkg.sv
package ght_pkg;

  localparam int DEF_SLOTS         = 64;
  localparam int DEF_GROW_STEP     = 8;
  localparam int DEF_SERIAL_WIDTH  = 16;
  localparam int DEF_PAYLOAD_WIDTH = 32;

  localparam int OP_W     = 2;
  localparam int STATUS_W = 3;

  // Operation codes.
  localparam logic [OP_W-1:0] OP_OPEN   = 2'd0;
  localparam logic [OP_W-1:0] OP_CLOSE  = 2'd1;
  localparam logic [OP_W-1:0] OP_LOOKUP = 2'd2;

  // Result status codes.
  localparam logic [STATUS_W-1:0] STAT_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] STAT_BAD_INDEX = 3'd1;
  localparam logic [STATUS_W-1:0] STAT_STALE     = 3'd2;
  localparam logic [STATUS_W-1:0] STAT_KIND      = 3'd3;
  localparam logic [STATUS_W-1:0] STAT_FULL      = 3'd4;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EVAL,
    S_REOPEN
  } state_t;

  // Requests from the controller to the free list.
  typedef struct packed {
    logic rd;    // read the entry at the head
    logic pop;   // advance the head
    logic push;  // append an index at the tail
  } fl_ctrl_t;

endpackage

>>> sv/ght_ram.sv
module ght_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> sv/ght_free_list.sv
module ght_free_list #(
  parameter int DEPTH = ght_pkg::DEF_SLOTS
) (
  input  logic                     clk,
  input  logic                     rst,
  input  ght_pkg::fl_ctrl_t        ctrl,
  input  logic [$clog2(DEPTH)-1:0] push_idx,
  output logic [$clog2(DEPTH)-1:0] head_idx,
  output logic                     empty
);
  import ght_pkg::*;

  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [IDX_W-1:0] LAST = IDX_W'(DEPTH - 1);

  logic [IDX_W-1:0] head;
  logic [IDX_W-1:0] tail;
  logic [CNT_W-1:0] count;

  // Ring pointers wrap at the depth, which need not be a power of two.
  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      if (ctrl.pop) begin
        head <= (head == LAST) ? '0 : head + 1'b1;
      end
      if (ctrl.push) begin
        tail <= (tail == LAST) ? '0 : tail + 1'b1;
      end
      if (ctrl.push && !ctrl.pop) begin
        count <= count + 1'b1;
      end else if (ctrl.pop && !ctrl.push) begin
        count <= count - 1'b1;
      end
    end
  end

  assign empty = (count == '0);

  ght_ram #(
    .WIDTH (IDX_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ctrl.push),
    .waddr (tail),
    .wdata (push_idx),
    .re    (ctrl.rd),
    .raddr (head),
    .rdata (head_idx)
  );

endmodule

>>> sv/generational_handle_table.sv
// Every item starts its reads on accept and loads the result register from S_EVAL, except an
// open that reuses a freed slot, which reads the free-list head, then that slot, and loads the
// result from S_REOPEN. One item is in flight at a time: a new item is taken only after the last
// one has loaded its result, set by the slot read-modify-write. A waiting result does not block the
// input: one more item is taken and waits in the controller until the result register frees up.
// Reset (rst, synchronous) clears the control state and counters; memories are not cleared and
// no clearing pass runs, so the block accepts items in the first cycle after reset.
module generational_handle_table #(
  parameter int SLOTS         = ght_pkg::DEF_SLOTS,
  parameter int GROW_STEP     = ght_pkg::DEF_GROW_STEP,
  parameter int SERIAL_WIDTH  = ght_pkg::DEF_SERIAL_WIDTH,
  parameter int PAYLOAD_WIDTH = ght_pkg::DEF_PAYLOAD_WIDTH
) (
  input  logic                                       clk,
  input  logic                                       rst,
  input  logic                                       in_valid,
  output logic                                       in_stall,
  input  logic [ght_pkg::OP_W-1:0]                   op,
  input  logic                                       handle_type,
  input  logic [PAYLOAD_WIDTH-1:0]                   payload,
  input  logic [$clog2(SLOTS)+SERIAL_WIDTH-1:0]      handle,
  output logic                                       out_valid,
  input  logic                                       out_stall,
  output logic [$clog2(SLOTS)+SERIAL_WIDTH-1:0]      handle_out,
  output logic [PAYLOAD_WIDTH-1:0]                   payload_out,
  output logic [ght_pkg::STATUS_W-1:0]               status
);
  import ght_pkg::*;

  localparam int IDX_W    = $clog2(SLOTS);
  localparam int CNT_W    = $clog2(SLOTS + 1);
  localparam int SW       = SERIAL_WIDTH;
  localparam int PW       = PAYLOAD_WIDTH;
  localparam int HW       = IDX_W + SW;
  localparam int GROW_EFF = (GROW_STEP < SLOTS) ? GROW_STEP : SLOTS;

  // Slot word layout: {live, kind, serial, payload}.
  localparam int SLOT_W = 2 + SW + PW;
  localparam int LIVE_B = SLOT_W - 1;
  localparam int KIND_B = SLOT_W - 2;

  localparam logic [CNT_W-1:0] SLOTS_C = CNT_W'(SLOTS);
  localparam logic [CNT_W-1:0] GROW_C  = CNT_W'(GROW_EFF);
  localparam logic [SW-1:0]    SER_ONE = SW'(1);

  // The free list is modelled in two parts. Slots created by the latest growth step and not yet
  // opened form a range from fresh_next up to created. Slots given back by close sit in a FIFO.
  // Growth only happens when both parts are empty, so every slot closed afterwards lands behind
  // the fresh range, and taking fresh slots first keeps the oldest-first order.
  //
  // Slots at or above fresh_next have never been opened and so never written in the slot
  // memory; they read as serial zero and not live. This doubles as the reset value of the
  // serial and live marks, so no clearing pass is needed.

  state_t           state;
  state_t           state_next;
  logic [OP_W-1:0]  op_q;
  logic             kind_q;
  logic [PW-1:0]    payload_q;
  logic [HW-1:0]    handle_q;
  logic [CNT_W-1:0] fresh_next;
  logic [CNT_W-1:0] created;

  logic              accept;
  logic              out_room;
  logic [IDX_W-1:0]  q_idx;
  logic [SW-1:0]     q_ser;
  logic              in_range;
  logic              opened;
  logic              rd_live;
  logic [SW-1:0]     rd_ser;
  logic              fresh_avail;
  logic              can_grow;
  logic              fresh_path;
  logic              reopen_path;
  logic [IDX_W-1:0]  fresh_idx;
  logic [CNT_W-1:0]  created_grown;

  logic              slot_we;
  logic [IDX_W-1:0]  slot_waddr;
  logic [SLOT_W-1:0] slot_wdata;
  logic              slot_re;
  logic [IDX_W-1:0]  slot_raddr;
  logic [SLOT_W-1:0] slot_rd;

  fl_ctrl_t          fl_ctrl;
  logic [IDX_W-1:0]  fl_head;
  logic              fl_empty;

  logic              res_load;
  logic [HW-1:0]     res_handle;
  logic [PW-1:0]     res_payload;
  logic [STATUS_W-1:0] res_status;
  logic              fresh_inc;
  logic              grow;

  // One item at a time: the input is open only while the controller is idle. The result
  // register decouples the output side, so a result that has not been taken yet does not stall
  // the input until the next result is ready to be loaded.
  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_room = !out_valid || !out_stall;

  assign q_idx    = handle_q[HW-1:SW];
  assign q_ser    = handle_q[SW-1:0];
  assign in_range = CNT_W'(q_idx) < created;
  assign opened   = CNT_W'(q_idx) < fresh_next;
  assign rd_live  = opened && slot_rd[LIVE_B];
  assign rd_ser   = opened ? slot_rd[PW +: SW] : '0;

  assign fresh_avail = fresh_next < created;
  assign can_grow    = created < SLOTS_C;
  assign fresh_idx   = fresh_next[IDX_W-1:0];
  // An open takes a fresh slot if one is left, else the oldest freed one, else it grows the
  // table. Growth adds GROW_STEP slots, or only what is left below SLOTS.
  assign fresh_path  = fresh_avail || (fl_empty && can_grow);
  assign reopen_path = (op_q == OP_OPEN) && !fresh_avail && !fl_empty;
  assign created_grown = ((SLOTS_C - created) < GROW_C) ? SLOTS_C : created + GROW_C;

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = S_EVAL;
        end
      end
      S_EVAL: begin
        if (reopen_path) begin
          state_next = S_REOPEN;
        end else if (out_room) begin
          state_next = S_IDLE;
        end
      end
      S_REOPEN: begin
        if (out_room) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Memory requests, counter updates and the result. Nothing is committed in a finishing
  // state until the result register can take the result, so a stalled output simply holds the
  // controller where it is with the registered read data unchanged.
  always_comb begin
    slot_we     = 1'b0;
    slot_waddr  = fresh_idx;
    slot_wdata  = {1'b1, kind_q, SER_ONE, payload_q};
    slot_re     = 1'b0;
    slot_raddr  = handle[HW-1:SW];
    fl_ctrl     = '0;
    res_load    = 1'b0;
    res_handle  = '0;
    res_payload = '0;
    res_status  = STAT_OK;
    fresh_inc   = 1'b0;
    grow        = 1'b0;
    case (state)
      S_IDLE: begin
        // Start both reads on accept: the addressed slot for close and lookup, the free-list
        // head for an open that may reuse a slot.
        slot_re    = accept;
        fl_ctrl.rd = accept;
      end
      S_EVAL: begin
        case (op_q)
          OP_OPEN: begin
            if (fresh_path) begin
              if (out_room) begin
                slot_we    = 1'b1;
                res_load   = 1'b1;
                res_handle = {fresh_idx, SER_ONE};
                fresh_inc  = 1'b1;
                grow       = !fresh_avail;
              end
            end else if (!fl_empty) begin
              slot_re     = 1'b1;
              slot_raddr  = fl_head;
              fl_ctrl.pop = 1'b1;
            end else if (out_room) begin
              res_load   = 1'b1;
              res_status = STAT_FULL;
            end
          end
          OP_CLOSE: begin
            if (out_room) begin
              res_load = 1'b1;
              if (!in_range) begin
                res_status = STAT_BAD_INDEX;
              end else if ((rd_ser != q_ser) || !rd_live) begin
                res_status = STAT_STALE;
              end else begin
                slot_we      = 1'b1;
                slot_waddr   = q_idx;
                slot_wdata   = {1'b0, slot_rd[KIND_B:0]};
                fl_ctrl.push = 1'b1;
              end
            end
          end
          OP_LOOKUP: begin
            if (out_room) begin
              res_load = 1'b1;
              if (!in_range) begin
                res_status = STAT_BAD_INDEX;
              end else if ((rd_ser != q_ser) || !rd_live) begin
                res_status = STAT_STALE;
              end else if (slot_rd[KIND_B] != kind_q) begin
                res_status = STAT_KIND;
              end else begin
                res_payload = slot_rd[PW-1:0];
              end
            end
          end
          default: begin
            res_load = out_room;
          end
        endcase
      end
      S_REOPEN: begin
        // The freed slot was opened before, so its stored serial is valid; bump it with wrap.
        if (out_room) begin
          slot_we    = 1'b1;
          slot_waddr = fl_head;
          slot_wdata = {1'b1, kind_q, slot_rd[PW +: SW] + SER_ONE, payload_q};
          res_load   = 1'b1;
          res_handle = {fl_head, slot_rd[PW +: SW] + SER_ONE};
        end
      end
      default: begin
        res_load = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      fresh_next <= '0;
      created    <= '0;
    end else begin
      state <= state_next;
      if (grow) begin
        created <= created_grown;
      end
      if (fresh_inc) begin
        fresh_next <= fresh_next + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_q      <= op;
      kind_q    <= handle_type;
      payload_q <= payload;
      handle_q  <= handle;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      handle_out  <= res_handle;
      payload_out <= res_payload;
      status      <= res_status;
    end
  end

  ght_ram #(
    .WIDTH (SLOT_W),
    .DEPTH (SLOTS)
  ) u_slot_ram (
    .clk   (clk),
    .we    (slot_we),
    .waddr (slot_waddr),
    .wdata (slot_wdata),
    .re    (slot_re),
    .raddr (slot_raddr),
    .rdata (slot_rd)
  );

  ght_free_list #(
    .DEPTH (SLOTS)
  ) u_free_list (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (fl_ctrl),
    .push_idx (q_idx),
    .head_idx (fl_head),
    .empty    (fl_empty)
  );

`ifndef NO_ASSERTIONS
  // The fresh range never runs past the slots created.
  a_fresh_bound: assert property (@(posedge clk) disable iff (rst)
    fresh_next <= created)
    else $error("fresh_next beyond created slots");

  // The table grows only once every created slot has been handed out at least once.
  a_grow_exhausted: assert property (@(posedge clk) disable iff (rst)
    grow |-> (fresh_next == created) && fl_empty)
    else $error("growth while free slots remain");

  // A result is loaded only when the previous one has gone or is leaving.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    res_load |-> (!out_valid || !out_stall))
    else $error("result register overwritten");

  // A slot returns to the free list only together with clearing its live mark.
  a_close_pair: assert property (@(posedge clk) disable iff (rst)
    fl_ctrl.push |-> slot_we && !slot_wdata[LIVE_B] && (slot_waddr == q_idx))
    else $error("free-list push without slot close");
`endif

endmodule

>>> sim/handle_table_checker.sv
module handle_table_checker
  import ght_pkg::*;
(
  input  logic                                         clk,
  input  logic                                         rst,
  input  logic                                         in_valid,
  input  logic                                         in_stall,
  input  logic [OP_W-1:0]                              op,
  input  logic                                         handle_type,
  input  logic [DEF_PAYLOAD_WIDTH-1:0]                 payload,
  input  logic [$clog2(DEF_SLOTS)+DEF_SERIAL_WIDTH-1:0] handle,
  input  logic                                         out_valid,
  input  logic                                         out_stall,
  input  logic [$clog2(DEF_SLOTS)+DEF_SERIAL_WIDTH-1:0] handle_out,
  input  logic [DEF_PAYLOAD_WIDTH-1:0]                 payload_out,
  input  logic [STATUS_W-1:0]                          status,
  output int                                           fail_count,
  output int                                           pending,
  output int                                           result_count,
  output int                                           full_count
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDX_W    = $clog2(DEF_SLOTS);
  localparam int SER_W    = DEF_SERIAL_WIDTH;
  localparam int PAY_W    = DEF_PAYLOAD_WIDTH;
  localparam int HANDLE_W = IDX_W + SER_W;

  typedef struct packed {
    logic [HANDLE_W-1:0] handle;
    logic [PAY_W-1:0]    payload;
    logic [STATUS_W-1:0] status;
  } table_answer_t;

  // Shadow copy of the table.
  int unsigned     free_slots[$];
  int              slots_made;
  logic [SER_W-1:0] serial_of[DEF_SLOTS];
  logic            kind_of[DEF_SLOTS];
  logic [PAY_W-1:0] stored_of[DEF_SLOTS];
  logic            live_of[DEF_SLOTS];

  table_answer_t   due_answers[$];

  // Applies one request to the shadow table and returns the answer it must produce.
  function automatic table_answer_t apply_to_table(input logic [OP_W-1:0] code,
                                                   input logic kind,
                                                   input logic [PAY_W-1:0] data,
                                                   input logic [HANDLE_W-1:0] h);
    table_answer_t ans;
    int            room;
    int            grow;
    int            idx;
    logic [SER_W-1:0] ser;
    ans = '0;
    case (code)
      OP_OPEN: begin
        if (free_slots.size() == 0) begin
          room = DEF_SLOTS - slots_made;
          grow = (room < DEF_GROW_STEP) ? room : DEF_GROW_STEP;
          for (int k = 0; k < grow; k++) begin
            serial_of[slots_made + k] = '0;
            live_of[slots_made + k]   = 1'b0;
            if (free_slots.size() < DEF_SLOTS) free_slots.push_back(slots_made + k);
          end
          slots_made += grow;
        end
        if (free_slots.size() == 0) begin
          ans.status = STAT_FULL;
        end else begin
          idx            = free_slots.pop_front();
          serial_of[idx] = serial_of[idx] + 1'b1;
          kind_of[idx]   = kind;
          stored_of[idx] = data;
          live_of[idx]   = 1'b1;
          ans.handle     = {IDX_W'(idx), serial_of[idx]};
        end
      end
      OP_CLOSE, OP_LOOKUP: begin
        idx = int'(h[HANDLE_W-1:SER_W]);
        ser = h[SER_W-1:0];
        if (idx >= slots_made) begin
          ans.status = STAT_BAD_INDEX;
        end else if (serial_of[idx] != ser || !live_of[idx]) begin
          ans.status = STAT_STALE;
        end else if (code == OP_CLOSE) begin
          live_of[idx] = 1'b0;
          if (free_slots.size() < DEF_SLOTS) free_slots.push_back(idx);
        end else if (kind_of[idx] != kind) begin
          ans.status = STAT_KIND;
        end else begin
          ans.payload = stored_of[idx];
        end
      end
      default: begin
      end
    endcase
    return ans;
  endfunction

  always @(posedge clk) begin
    table_answer_t want;
    table_answer_t got;
    if (rst) begin
      free_slots.delete();
      due_answers.delete();
      slots_made = 0;
      for (int s = 0; s < DEF_SLOTS; s++) begin
        serial_of[s] = '0;
        live_of[s]   = 1'b0;
      end
    end else begin
      // The result leaving now belongs to an earlier request, so it is checked first.
      if (out_valid && !out_stall) begin
        got = {handle_out, payload_out, status};
        result_count++;
        if (status == STAT_FULL) full_count++;
        if (due_answers.size() == 0) begin
          if (fail_count < 10)
            $display("%0t: unexpected result: handle %h payload %h status %0d",
                     $realtime, handle_out, payload_out, status);
          fail_count++;
        end else begin
          want = due_answers.pop_front();
          if (got !== want) begin
            if (fail_count < 10)
              $display("%0t: mismatch: expected handle %h payload %h status %0d, got %h %h %0d",
                       $realtime, want.handle, want.payload, want.status,
                       handle_out, payload_out, status);
            fail_count++;
          end
        end
      end
      if (in_valid && !in_stall)
        due_answers.push_back(apply_to_table(op, handle_type, payload, handle));
    end
    pending = due_answers.size();
  end

endmodule

>>> sim/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import ght_pkg::*;

  localparam int IDX_W    = $clog2(DEF_SLOTS);
  localparam int SER_W    = DEF_SERIAL_WIDTH;
  localparam int PAY_W    = DEF_PAYLOAD_WIDTH;
  localparam int HANDLE_W = IDX_W + SER_W;

  // The op field has one code that the table does not define; it must do nothing.
  localparam logic [OP_W-1:0] OP_SPARE = 2'd3;

  // The slot that the directed items close last, leaving it alone on the free list.
  localparam int FREED_SLOT = 5;

  logic                clk         = 1'b0;
  logic                rst         = 1'b1;
  logic                in_valid    = 1'b0;
  logic                in_stall;
  logic [OP_W-1:0]     op          = OP_OPEN;
  logic                handle_type = 1'b0;
  logic [PAY_W-1:0]    payload     = '0;
  logic [HANDLE_W-1:0] handle      = '0;
  logic                out_valid;
  logic                out_stall   = 1'b0;
  logic [HANDLE_W-1:0] handle_out;
  logic [PAY_W-1:0]    payload_out;
  logic [STATUS_W-1:0] status;

  int fail_count;
  int pending;
  int result_count;
  int full_count;

  // Knobs for the sender and receiver; the idle and stall rates are in percent of cycles.
  int idle_pct    = 0;
  int stall_pct   = 0;
  int hold_cycles = 0;
  int items_offered = 0;

  // Handles the table has handed out and not yet been asked to close, and handles that were
  // closed. Both are used to aim close and lookup requests at real slots.
  logic [HANDLE_W-1:0] open_handles[$];
  logic [HANDLE_W-1:0] closed_handles[$];
  bit                  collect_handles = 1'b0;

  always #5 clk = ~clk;

  generational_handle_table u_top (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .op          (op),
    .handle_type (handle_type),
    .payload     (payload),
    .handle      (handle),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .handle_out  (handle_out),
    .payload_out (payload_out),
    .status      (status)
  );

  handle_table_checker u_check (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .op           (op),
    .handle_type  (handle_type),
    .payload      (payload),
    .handle       (handle),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .handle_out   (handle_out),
    .payload_out  (payload_out),
    .status       (status),
    .fail_count   (fail_count),
    .pending      (pending),
    .result_count (result_count),
    .full_count   (full_count)
  );

  // The receiver either stalls at random or, when a hold-off has been requested, keeps the
  // output stalled for that many cycles, counted here, so that the table backs up its input.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_cycles > 0) begin
        out_stall <= 1'b1;
        hold_cycles--;
      end else begin
        out_stall <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  // Every successful open hands back a fresh handle, which goes into the pool of live handles.
  // Sampling at the edge sees the values that the table saw.
  always @(posedge clk) begin
    if (collect_handles && out_valid && !out_stall && status == STAT_OK && handle_out != '0)
      open_handles.push_back(handle_out);
  end

  // Offers one item. Before it the sender may sit idle for a random number of cycles; once
  // offered, the item is held unchanged until the table takes it. Valid stays high from one
  // item to the next when no gap is drawn.
  task automatic offer(input logic [OP_W-1:0] code, input logic kind,
                       input logic [PAY_W-1:0] data, input logic [HANDLE_W-1:0] h);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    op          <= code;
    handle_type <= kind;
    payload     <= data;
    handle      <= h;
    do @(posedge clk); while (in_stall);
    items_offered++;
  endtask

  // Draws one random request. Most close and lookup requests use a handle the table handed
  // out, some use a handle that was already closed, and the rest use arbitrary bits.
  task automatic random_request(input int open_w, input int close_w, input int lookup_w);
    int                  r;
    int                  n;
    int                  k;
    logic [OP_W-1:0]     code;
    logic [HANDLE_W-1:0] h;
    r    = $urandom_range(99);
    n    = $urandom_range(99);
    h    = HANDLE_W'($urandom());
    code = OP_SPARE;
    if (r < open_w) begin
      code = OP_OPEN;
    end else if (r < open_w + close_w) begin
      code = OP_CLOSE;
      if (n < 70 && open_handles.size() > 0) begin
        k = $urandom_range(open_handles.size() - 1);
        h = open_handles[k];
        open_handles.delete(k);
        closed_handles.push_back(h);
        if (closed_handles.size() > 32) void'(closed_handles.pop_front());
      end else if (n < 85 && closed_handles.size() > 0) begin
        h = closed_handles[$urandom_range(closed_handles.size() - 1)];
      end
    end else if (r < open_w + close_w + lookup_w) begin
      code = OP_LOOKUP;
      if (n < 80 && open_handles.size() > 0)
        h = open_handles[$urandom_range(open_handles.size() - 1)];
      else if (n < 90 && closed_handles.size() > 0)
        h = closed_handles[$urandom_range(closed_handles.size() - 1)];
    end
    offer(code, 1'($urandom_range(1)), $urandom(), h);
  endtask

  task automatic run_phase(input int n, input int open_w, input int close_w,
                           input int lookup_w);
    for (int i = 0; i < n; i++) random_request(open_w, close_w, lookup_w);
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed items. Nothing exists yet, so the first two requests name a slot beyond the
    // created range, one with every handle bit set.
    offer(OP_LOOKUP, 1'b0, '0, '0);
    offer(OP_CLOSE, 1'b1, '1, '1);
    // The first open grows the table by eight slots and takes slot 0; the second takes slot 1.
    offer(OP_OPEN, 1'b0, '0, '0);
    offer(OP_OPEN, 1'b1, '1, '1);
    // Good lookups, then a wrong kind, a wrong serial, an index past the created slots and a
    // created slot that was never opened.
    offer(OP_LOOKUP, 1'b0, '0, 22'h00001);
    offer(OP_LOOKUP, 1'b1, '0, 22'h10001);
    offer(OP_LOOKUP, 1'b0, '0, 22'h10001);
    offer(OP_LOOKUP, 1'b1, '0, 22'h10002);
    offer(OP_LOOKUP, 1'b0, '0, 22'h80001);
    offer(OP_LOOKUP, 1'b0, '0, 22'h70000);
    // Close ignores the kind; a second close of the same slot must be refused and must not
    // put the slot on the free list twice.
    offer(OP_CLOSE, 1'b0, '0, 22'h10001);
    offer(OP_CLOSE, 1'b1, '0, 22'h10001);
    offer(OP_LOOKUP, 1'b1, '0, 22'h10001);
    // The undefined op code with all fields set and all fields clear.
    offer(OP_SPARE, 1'b1, '1, '1);
    offer(OP_SPARE, 1'b0, '0, '0);
    // Use up the free list in its order: slots 2 to 7, then slot 1 with its second serial.
    for (int i = 0; i < 7; i++) offer(OP_OPEN, 1'(i), $urandom(), '0);
    // Every created slot is now live. Closing one leaves it alone on the free list.
    offer(OP_CLOSE, 1'b0, '0, {IDX_W'(FREED_SLOT), SER_W'(1)});
    in_valid <= 1'b0;

    repeat (2) @(posedge clk);
    while (pending != 0) @(posedge clk);

    // Hand the random part the slots that the directed items left open.
    open_handles = '{22'h00001, 22'h10002, 22'h20001, 22'h30001, 22'h40001, 22'h60001,
                     22'h70001};
    collect_handles = 1'b1;

    // Open-heavy with no idling, so the table grows to its full size and refuses opens.
    run_phase(110, 75, 12, 10);
    // Sender idle most of the time.
    idle_pct = 74;
    run_phase(110, 45, 30, 22);
    // Receiver stalls most of the time; it starts with a long hold-off while items keep
    // coming, so the table fills its output and stalls its input.
    idle_pct    = 0;
    stall_pct   = 74;
    hold_cycles = 80;
    run_phase(110, 40, 35, 22);
    // Light idling on both sides with more closes than opens.
    idle_pct  = 10;
    stall_pct = 10;
    run_phase(120, 30, 40, 27);
    in_valid <= 1'b0;

    repeat (2) @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Covered %0d items and %0d checked results; %0d opens were refused as full.",
             items_offered, result_count, full_count);
    $display("Bad indexes, stale and double closes, kind mismatches and the spare op were hit;");
    $display("idling: none, sender, receiver with a long hold-off, both.");
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Backstop for a hung handshake or a result that never comes.
  initial begin
    #40ms;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

>>> sim.f
sv/ght_pkg.sv
sv/ght_ram.sv
sv/ght_free_list.sv
sv/generational_handle_table.sv
sim/handle_table_checker.sv
sim/tb_top.sv
